// ===== hw/rtl/lpht_pkg.sv =====
package lpht_pkg;

	localparam int TABLE_SIZE = 16;
	localparam int ADDR_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);
	localparam int KEY_W = 32;
	localparam int DATA_W = 32;
	localparam int COUNT_W = 5;
	localparam bit SIZE_IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;

	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_ABSENT = 2'd1;
	localparam logic [1:0] STATUS_PRESENT = 2'd2;
	localparam logic [1:0] STATUS_FULL = 2'd3;

	localparam logic [1:0] TAG_EMPTY = 2'd0;
	localparam logic [1:0] TAG_LIVE = 2'd1;
	localparam logic [1:0] TAG_TOMB = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [KEY_W-1:0] key;
		logic signed [DATA_W-1:0] value;
	} lpht_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [DATA_W-1:0] found_value;
		logic [COUNT_W-1:0] entry_count;
	} lpht_rsp_t;

	// Folds eight more key bits, most significant first, into a running
	// remainder modulo the table size.
	function automatic logic [ADDR_W-1:0] mod_byte(input logic [ADDR_W-1:0] rem,
			input logic [7:0] bits);
		logic [ADDR_W:0] t;
		logic [ADDR_W-1:0] r;
		r = rem;
		for (int i = 7; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= (ADDR_W + 1)'(TABLE_SIZE)) begin
				t = t - (ADDR_W + 1)'(TABLE_SIZE);
			end
			r = t[ADDR_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/lpht_ram.sv =====
module lpht_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/linear_probe_hash_table.sv =====
// After acceptance the probe reads slots from the home slot on until a live match, an empty
// slot or every slot visited (1 to TABLE_SIZE slots); FINISH then registers the response.
// A table size that is not a power of two first finds the home slot in the HOME state.
// One request at a time; the next is accepted the cycle after the response is registered,
// and FINISH waits while the previous response is still held by rsp_stall.
// Reset clears all slot tags to empty and the live count to zero at once; no clearing pass.
module linear_probe_hash_table import lpht_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input lpht_req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output lpht_rsp_t rsp
);

	typedef enum logic [1:0] {
		IDLE,
		HOME,
		PROBE,
		FINISH
	} state_t;

	state_t state_q;
	logic [1:0] mode_q;
	logic [KEY_W-1:0] key_q;
	logic [DATA_W-1:0] value_q;
	logic [KEY_W-1:0] kshift_q;
	logic [1:0] byte_q;
	logic [ADDR_W-1:0] pos_q;
	logic [CNT_W-1:0] issued_q;
	logic s1_valid_q;
	logic [1:0] s1_tag_q;
	logic [ADDR_W-1:0] s1_pos_q;
	logic hit_q;
	logic [ADDR_W-1:0] hit_pos_q;
	logic [DATA_W-1:0] found_q;
	logic tomb_found_q;
	logic [ADDR_W-1:0] tomb_pos_q;
	logic empty_found_q;
	logic [ADDR_W-1:0] empty_pos_q;
	logic [COUNT_W-1:0] count_q;
	logic [1:0] tag_q [TABLE_SIZE];
	logic out_valid_q;
	lpht_rsp_t rsp_q;

	logic [KEY_W+DATA_W-1:0] rd_data;
	logic s1_hit;
	logic s1_empty;
	logic issue;
	logic probe_end;
	logic out_free;
	logic commit;
	logic ram_we;
	logic tag_we;
	logic [1:0] tag_wval;
	logic [ADDR_W-1:0] tag_waddr;
	logic [1:0] res_status;
	logic [DATA_W-1:0] res_found;
	logic [COUNT_W-1:0] count_next;
	logic [ADDR_W-1:0] dst;

	lpht_ram #(
		.WIDTH(KEY_W + DATA_W),
		.DEPTH(TABLE_SIZE)
	) u_slot_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(dst),
		.wdata({key_q, value_q}),
		.re(issue),
		.raddr(pos_q),
		.rdata(rd_data)
	);

	assign req_stall = (state_q != IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp = rsp_q;

	assign s1_hit = s1_valid_q && (s1_tag_q == TAG_LIVE) && (rd_data[KEY_W+DATA_W-1:DATA_W] == key_q);
	assign s1_empty = s1_valid_q && (s1_tag_q == TAG_EMPTY);
	assign issue = (state_q == PROBE) && !s1_hit && !s1_empty && (issued_q != CNT_W'(TABLE_SIZE));
	assign probe_end = s1_hit || s1_empty || (!s1_valid_q && (issued_q == CNT_W'(TABLE_SIZE)));
	assign out_free = !out_valid_q || !rsp_stall;
	assign commit = (state_q == FINISH) && out_free;
	assign dst = tomb_found_q ? tomb_pos_q : empty_pos_q;

	always_comb begin
		res_status = STATUS_ABSENT;
		res_found = '0;
		count_next = count_q;
		ram_we = 1'b0;
		tag_we = 1'b0;
		tag_wval = TAG_EMPTY;
		tag_waddr = hit_pos_q;
		case (mode_q)
			MODE_INSERT: begin
				tag_waddr = dst;
				if (hit_q) begin
					res_status = STATUS_PRESENT;
				end else if (tomb_found_q || empty_found_q) begin
					res_status = STATUS_DONE;
					ram_we = commit;
					tag_we = commit;
					tag_wval = TAG_LIVE;
					count_next = count_q + COUNT_W'(1);
				end else begin
					res_status = STATUS_FULL;
				end
			end
			MODE_DELETE: begin
				if (hit_q) begin
					res_status = STATUS_DONE;
					tag_we = commit;
					tag_wval = TAG_TOMB;
					if (count_q != '0) begin
						count_next = count_q - COUNT_W'(1);
					end
				end
			end
			default: begin
				if (hit_q) begin
					res_status = STATUS_DONE;
					res_found = found_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			s1_valid_q <= 1'b0;
			count_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TABLE_SIZE; i++) begin
				tag_q[i] <= TAG_EMPTY;
			end
		end else begin
			if (out_valid_q && !rsp_stall && !commit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (req_valid) begin
						mode_q <= req.mode;
						key_q <= req.key;
						value_q <= req.value;
						kshift_q <= req.key;
						byte_q <= '0;
						issued_q <= '0;
						s1_valid_q <= 1'b0;
						hit_q <= 1'b0;
						tomb_found_q <= 1'b0;
						empty_found_q <= 1'b0;
						if (SIZE_IS_POW2) begin
							pos_q <= req.key[ADDR_W-1:0];
							state_q <= PROBE;
						end else begin
							pos_q <= '0;
							state_q <= HOME;
						end
					end
				end
				HOME: begin
					pos_q <= mod_byte(pos_q, kshift_q[KEY_W-1 -: 8]);
					kshift_q <= kshift_q << 8;
					byte_q <= byte_q + 2'd1;
					if (byte_q == 2'd3) begin
						state_q <= PROBE;
					end
				end
				PROBE: begin
					if (s1_hit) begin
						hit_q <= 1'b1;
						hit_pos_q <= s1_pos_q;
						found_q <= rd_data[DATA_W-1:0];
					end
					if (s1_empty) begin
						empty_found_q <= 1'b1;
						empty_pos_q <= s1_pos_q;
					end
					if (s1_valid_q && (s1_tag_q == TAG_TOMB) && !tomb_found_q) begin
						tomb_found_q <= 1'b1;
						tomb_pos_q <= s1_pos_q;
					end
					s1_valid_q <= issue;
					s1_tag_q <= tag_q[pos_q];
					s1_pos_q <= pos_q;
					if (issue) begin
						issued_q <= issued_q + CNT_W'(1);
						if (pos_q == ADDR_W'(TABLE_SIZE - 1)) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + ADDR_W'(1);
						end
					end
					if (probe_end) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						if (tag_we) begin
							tag_q[tag_waddr] <= tag_wval;
						end
						count_q <= count_next;
						rsp_q.status <= res_status;
						rsp_q.found_value <= res_found;
						rsp_q.entry_count <= count_next;
						out_valid_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sim/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpht_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 900;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = TABLE_SIZE + 3 + 4 + 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	lpht_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	lpht_rsp_t rsp;

	lpht_req_t pending_reqs[$];
	lpht_rsp_t expected_rsp[$];

	logic [KEY_W-1:0] table_key[TABLE_SIZE];
	logic [DATA_W-1:0] table_data[TABLE_SIZE];
	logic [1:0] table_tag[TABLE_SIZE];
	int live_entries;

	int queued;
	int sent;
	int received;
	int mismatches;
	int status_seen[4];
	int burst_left;
	int gap_left;
	int stall_left;
	int idle_cycles;

	linear_probe_hash_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #1ns clk = ~clk;

	// Walks the probe chain from the home slot and applies the request to the table copy.
	function automatic lpht_rsp_t apply_request(lpht_req_t r);
		lpht_rsp_t o;
		int pos;
		int hit;
		int tomb;
		int hole;
		int dst;
		bit stop;
		o.status = STATUS_ABSENT;
		o.found_value = '0;
		pos = int'(r.key % 32'(TABLE_SIZE));
		hit = -1;
		tomb = -1;
		hole = -1;
		stop = 1'b0;
		for (int n = 0; n < TABLE_SIZE && !stop; n++) begin
			if (table_tag[pos] == TAG_EMPTY) begin
				hole = pos;
				stop = 1'b1;
			end else if (table_tag[pos] == TAG_LIVE) begin
				if (table_key[pos] == r.key) begin
					hit = pos;
					stop = 1'b1;
				end
			end else if (tomb < 0) begin
				tomb = pos;
			end
			if (!stop) begin
				pos = (pos + 1) % TABLE_SIZE;
			end
		end
		case (r.mode)
			MODE_INSERT: begin
				if (hit >= 0) begin
					o.status = STATUS_PRESENT;
				end else begin
					dst = (tomb >= 0) ? tomb : hole;
					if (dst >= 0) begin
						table_key[dst] = r.key;
						table_data[dst] = r.value;
						table_tag[dst] = TAG_LIVE;
						live_entries++;
						o.status = STATUS_DONE;
					end else begin
						o.status = STATUS_FULL;
					end
				end
			end
			MODE_DELETE: begin
				if (hit >= 0) begin
					table_tag[hit] = TAG_TOMB;
					if (live_entries > 0) begin
						live_entries--;
					end
					o.status = STATUS_DONE;
				end
			end
			default: begin
				if (hit >= 0) begin
					o.found_value = table_data[hit];
					o.status = STATUS_DONE;
				end
			end
		endcase
		o.entry_count = COUNT_W'(live_entries);
		return o;
	endfunction

	task automatic queue_req(logic [1:0] m, logic [KEY_W-1:0] k, logic [DATA_W-1:0] v);
		lpht_req_t r;
		r.mode = m;
		r.key = k;
		r.value = v;
		pending_reqs.push_back(r);
		queued++;
	endtask

	function automatic logic [DATA_W-1:0] make_value();
		case ($urandom_range(0, 11))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Nine keys in ten take one of spread home slots from base on, so that probe chains grow, wrap and cross tombstones.
	function automatic logic [KEY_W-1:0] make_key(int base, int spread);
		logic [KEY_W-1:0] k;
		int home;
		k = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			return k;
		end
		home = (base + $urandom_range(0, spread - 1)) % TABLE_SIZE;
		return (k / KEY_W'(TABLE_SIZE)) * KEY_W'(TABLE_SIZE) + KEY_W'(home);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_rsp.push_back(apply_request(req));
				status_seen[expected_rsp[$].status]++;
				sent++;
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					rsp_stall <= 1'b0;
					stall_left <= $urandom_range(8, 60);
				end
				1: begin
					rsp_stall <= 1'b1;
					stall_left <= $urandom_range(1, 20);
				end
				default: begin
					rsp_stall <= 1'($urandom_range(0, 1));
					stall_left <= 0;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		lpht_rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			received++;
			if (expected_rsp.size() == 0) begin
				$error("response with no request outstanding: status %0d", rsp.status);
				mismatches++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, rsp.status);
					mismatches++;
				end
				if (rsp.found_value !== e.found_value) begin
					$error("found_value: expected %0d, got %0d", e.found_value, rsp.found_value);
					mismatches++;
				end
				if (rsp.entry_count !== e.entry_count) begin
					$error("entry_count: expected %0d, got %0d", e.entry_count, rsp.entry_count);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int round;
		int pool_size;
		int spread;
		int base;
		int idx;
		int target;
		int r;
		logic [KEY_W-1:0] pool[$];

		foreach (table_tag[i]) begin
			table_tag[i] = TAG_EMPTY;
			table_key[i] = '0;
			table_data[i] = '0;
		end
		live_entries = 0;

		queue_req(MODE_LOOKUP, 32'h0000_0000, 32'h1234_5678);
		queue_req(MODE_DELETE, 32'hFFFF_FFFF, 32'h0);
		queue_req(MODE_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
		queue_req(MODE_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);
		queue_req(MODE_INSERT, 32'h0000_0010, 32'hFFFF_FFFF);
		queue_req(MODE_INSERT, 32'h0000_0020, 32'h0000_0000);
		queue_req(MODE_INSERT, 32'h0000_0000, 32'h5555_5555);
		queue_req(MODE_LOOKUP, 32'h0000_0020, 32'h0);
		queue_req(MODE_DELETE, 32'h0000_0010, 32'hFFFF_FFFF);
		queue_req(MODE_LOOKUP, 32'h0000_0020, 32'h0);
		queue_req(MODE_LOOKUP, 32'h0000_0010, 32'h0);
		queue_req(MODE_INSERT, 32'h0000_0030, 32'hAAAA_AAAA);
		queue_req(MODE_SPARE, 32'h0000_0030, 32'h0);
		queue_req(MODE_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
		queue_req(MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0);
		queue_req(MODE_DELETE, 32'hFFFF_FFFF, 32'h0);
		queue_req(MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0);
		queue_req(MODE_DELETE, 32'hFFFF_FFFF, 32'h0);
		queue_req(MODE_INSERT, 32'h5555_5555, 32'hA5A5_A5A5);
		queue_req(MODE_SPARE, 32'hDEAD_0000, 32'hFFFF_FFFF);

		// Early rounds keep to a few home slots so that empty slots remain to end probes;
		// later rounds fill the table, overflow it and drain it to tombstones.
		target = queued + RANDOM_ITEMS;
		round = 0;
		while (queued < target) begin
			pool_size = (round < 3) ? 3 + 2 * round : $urandom_range(6, TABLE_SIZE + 6);
			spread = (round < 3) ? 3 : $urandom_range(1, TABLE_SIZE);
			base = $urandom_range(0, TABLE_SIZE - 1);
			pool.delete();
			for (int i = 0; i < pool_size; i++) begin
				pool.push_back(make_key(base, spread));
			end
			foreach (pool[i]) begin
				queue_req(MODE_INSERT, pool[i], make_value());
			end
			repeat (2) queue_req(MODE_LOOKUP, make_key(base, spread), make_value());
			repeat (30) begin
				r = $urandom_range(0, 19);
				idx = $urandom_range(0, pool.size() - 1);
				queue_req((r < 7) ? MODE_LOOKUP : (r < 13) ? MODE_INSERT :
						(r < 19) ? MODE_DELETE : MODE_SPARE,
						($urandom_range(0, 9) == 0) ? make_key(base, spread) : pool[idx],
						make_value());
			end
			while (pool.size() > 0) begin
				idx = $urandom_range(0, pool.size() - 1);
				queue_req(MODE_DELETE, pool[idx], make_value());
				pool.delete(idx);
			end
			round++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || req_valid) begin
			@(posedge clk);
		end
		while (expected_rsp.size() > 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d requests over %0d table rounds; %0d responses checked.",
				sent, round, received);
		$display("Statuses: %0d done, %0d absent, %0d present, %0d full.",
				status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0 && expected_rsp.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_ram.sv
hw/rtl/linear_probe_hash_table.sv
sim/tb.sv
